[hw/rtl/sid_pkg.sv]
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types and constants for the signed integer divider: operand width,
// request and response structs, cell control and controller states.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int SID_WIDTH = 32;
    localparam int SID_CNT_W = $clog2(SID_WIDTH);
    localparam logic [SID_CNT_W-1:0] SID_LAST_STEP = SID_CNT_W'(SID_WIDTH - 1);

    typedef struct packed {
        logic signed [SID_WIDTH-1:0] dividend;
        logic signed [SID_WIDTH-1:0] divisor;
    } sid_req_t;

    typedef struct packed {
        logic signed [SID_WIDTH-1:0] quotient;
        logic                        overflow;
        logic                        divide_by_zero;
    } sid_rsp_t;

    typedef struct packed {
        logic load;
        logic step;
        logic take;
    } sid_ctrl_t;

    typedef enum logic [1:0] {
        SID_IDLE,
        SID_RUN,
        SID_FINISH
    } sid_state_t;

endpackage

[hw/rtl/sid_cell.sv]
// ----------------------------------------------------------------------------
// sid_cell
// One bit slice of the divider: a remainder bit, a dividend/quotient bit and
// a divisor bit, with one stage of the trial-subtract borrow chain.
// ----------------------------------------------------------------------------
module sid_cell
    import sid_pkg::*;
(
    input  logic      clk,
    input  sid_ctrl_t ctrl,
    input  logic      load_q,
    input  logic      load_d,
    input  logic      rem_in,
    input  logic      q_in,
    input  logic      borrow_in,
    output logic      borrow_out,
    output logic      rem_bit,
    output logic      q_bit
);

    logic rem_reg;
    logic rem_next;
    logic q_reg;
    logic q_next;
    logic d_reg;
    logic d_next;
    logic diff;

    // trial subtract of the shifted remainder bit
    assign diff       = rem_in ^ d_reg ^ borrow_in;
    assign borrow_out = (~rem_in & d_reg) | (~(rem_in ^ d_reg) & borrow_in);

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        d_next   = d_reg;
        if (ctrl.load)
        begin
            rem_next = 1'b0;
            q_next   = load_q;
            d_next   = load_d;
        end
        else if (ctrl.step)
        begin
            rem_next = ctrl.take ? diff : rem_in;
            q_next   = q_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign rem_bit = rem_reg;
    assign q_bit   = q_reg;

endmodule

[hw/rtl/signed_int_divider.sv]
// ----------------------------------------------------------------------------
// signed_int_divider
// Signed 32-bit divider, quotient truncated toward zero, restoring
// shift-subtract over a row of bit-slice cells.
// ----------------------------------------------------------------------------
// sequence: after acceptance the 32 cell steps run (one quotient bit per
// cycle), then the FINISH state applies sign and saturation and loads the
// result register; busy holds off new requests until the result is shown.
// zero divisor: result in the cycle after acceptance, next request at once.
// reset clears the controller and the done strobe; the receiver cannot stall.
module signed_int_divider
    import sid_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  sid_req_t req,
    output logic     done,
    output sid_rsp_t rsp
);

    sid_state_t state_reg;
    sid_state_t state_next;
    logic [SID_CNT_W-1:0] cnt_reg;
    logic [SID_CNT_W-1:0] cnt_next;
    logic neg_reg;
    logic neg_next;
    logic done_reg;
    logic done_next;
    sid_rsp_t rsp_reg;
    sid_rsp_t rsp_next;

    sid_ctrl_t ctrl;
    logic accept;
    logic [SID_WIDTH-1:0] a_bits;
    logic [SID_WIDTH-1:0] b_bits;
    logic [SID_WIDTH-1:0] mag_a;
    logic [SID_WIDTH-1:0] mag_b;
    logic [SID_WIDTH-1:0] rem_bits;
    logic [SID_WIDTH-1:0] q_bits;
    logic [SID_WIDTH-1:0] rem_shift;
    logic [SID_WIDTH-1:0] q_shift;
    logic [SID_WIDTH:0]   borrow;

    assign a_bits = req.dividend;
    assign b_bits = req.divisor;
    assign mag_a  = a_bits[SID_WIDTH-1] ? (~a_bits + 1'b1) : a_bits;
    assign mag_b  = b_bits[SID_WIDTH-1] ? (~b_bits + 1'b1) : b_bits;

    assign accept = start && (state_reg == SID_IDLE);

    // chain wiring: remainder takes the top dividend bit, quotient the decision
    assign rem_shift = {rem_bits[SID_WIDTH-2:0], q_bits[SID_WIDTH-1]};
    assign q_shift   = {q_bits[SID_WIDTH-2:0], ctrl.take};
    assign borrow[0] = 1'b0;

    generate
        for (genvar i = 0; i < SID_WIDTH; i++)
        begin : g_cell
            sid_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .load_q     (mag_a[i]),
                .load_d     (mag_b[i]),
                .rem_in     (rem_shift[i]),
                .q_in       (q_shift[i]),
                .borrow_in  (borrow[i]),
                .borrow_out (borrow[i+1]),
                .rem_bit    (rem_bits[i]),
                .q_bit      (q_bits[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        ctrl.load  = 1'b0;
        ctrl.step  = 1'b0;
        ctrl.take  = ~borrow[SID_WIDTH];
        unique case (state_reg)
            SID_IDLE:
            begin
                if (accept)
                begin
                    if (b_bits == '0)
                    begin
                        done_next               = 1'b1;
                        rsp_next.quotient       = '0;
                        rsp_next.overflow       = 1'b0;
                        rsp_next.divide_by_zero = 1'b1;
                    end
                    else
                    begin
                        ctrl.load  = 1'b1;
                        neg_next   = a_bits[SID_WIDTH-1] ^ b_bits[SID_WIDTH-1];
                        cnt_next   = SID_LAST_STEP;
                        state_next = SID_RUN;
                    end
                end
            end
            SID_RUN:
            begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = SID_FINISH;
                end
            end
            SID_FINISH:
            begin
                done_next               = 1'b1;
                rsp_next.divide_by_zero = 1'b0;
                if (neg_reg)
                begin
                    rsp_next.quotient = signed'(~q_bits + 1'b1);
                    rsp_next.overflow = 1'b0;
                end
                else if (q_bits[SID_WIDTH-1])
                begin
                    // only the most negative value over minus one lands here
                    rsp_next.quotient = signed'({1'b0, {(SID_WIDTH-1){1'b1}}});
                    rsp_next.overflow = 1'b1;
                end
                else
                begin
                    rsp_next.quotient = signed'(q_bits);
                    rsp_next.overflow = 1'b0;
                end
                state_next = SID_IDLE;
            end
            default:
            begin
                state_next = SID_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SID_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != SID_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while divider still running");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.overflow && rsp.divide_by_zero))
        else $error("overflow and divide by zero raised together");

    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.divide_by_zero) |-> (rsp.quotient == '0))
        else $error("zero divisor result has nonzero quotient");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.divisor != '0)) |=> (busy && !done))
        else $error("accepted request did not start the cell chain");

endmodule

[test/signed_int_divider_checker.sv]
// ----------------------------------------------------------------------------
// signed_int_divider_checker
// Watches the request and result channels of the signed divider. Each
// accepted request is divided here as well, truncating toward zero, with
// the saturation and zero-divisor rules. Every strobed result is compared
// field by field with the oldest quotient still due.
// ----------------------------------------------------------------------------
module signed_int_divider_checker
    import sid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  sid_req_t    req,
    input  logic        done,
    input  sid_rsp_t    rsp,
    output int unsigned mismatches,
    output int unsigned outstanding,
    output int unsigned requests_taken,
    output int unsigned results_checked,
    output int unsigned overflows_seen,
    output int unsigned zero_divides_seen,
    output int unsigned negatives_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        sid_req_t op;
        sid_rsp_t want;
    } quotient_due_t;

    quotient_due_t quotients_due[$];

    int unsigned n_mismatch = 0;
    int unsigned n_due      = 0;
    int unsigned n_taken    = 0;
    int unsigned n_checked  = 0;
    int unsigned n_overflow = 0;
    int unsigned n_zero_div = 0;
    int unsigned n_negative = 0;

    assign mismatches        = n_mismatch;
    assign outstanding       = n_due;
    assign requests_taken    = n_taken;
    assign results_checked   = n_checked;
    assign overflows_seen    = n_overflow;
    assign zero_divides_seen = n_zero_div;
    assign negatives_seen    = n_negative;

    function automatic sid_rsp_t divide_truncated(input sid_req_t op);
        logic [SID_WIDTH:0] num_mag;
        logic [SID_WIDTH:0] den_mag;
        logic [SID_WIDTH:0] partial;
        logic [SID_WIDTH:0] q_mag;
        logic               negative;
        sid_rsp_t           res;
        res = '0;
        if (op.divisor == '0)
        begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        negative = op.dividend[SID_WIDTH-1] ^ op.divisor[SID_WIDTH-1];
        // magnitudes one bit wider so the most negative value fits
        num_mag = {op.dividend[SID_WIDTH-1], op.dividend};
        den_mag = {op.divisor[SID_WIDTH-1], op.divisor};
        if (op.dividend[SID_WIDTH-1])
            num_mag = ~num_mag + 1'b1;
        if (op.divisor[SID_WIDTH-1])
            den_mag = ~den_mag + 1'b1;
        partial = '0;
        q_mag   = '0;
        for (int i = SID_WIDTH - 1; i >= 0; i--)
        begin
            partial = {partial[SID_WIDTH-1:0], num_mag[i]};
            q_mag   = q_mag << 1;
            if (partial >= den_mag)
            begin
                partial  = partial - den_mag;
                q_mag[0] = 1'b1;
            end
        end
        if (!negative && q_mag[SID_WIDTH-1])
        begin
            res.quotient = {1'b0, {(SID_WIDTH-1){1'b1}}};
            res.overflow = 1'b1;
        end
        else if (negative)
            res.quotient = ~q_mag[SID_WIDTH-1:0] + 1'b1;
        else
            res.quotient = q_mag[SID_WIDTH-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_mismatch++;
    endtask

    always @(posedge clk)
    begin
        quotient_due_t head;
        if (rst_n)
        begin
            if (done)
            begin
                if (quotients_due.size() == 0)
                    report_mismatch($sformatf("result %0d with no request pending",
                                              rsp.quotient));
                else
                begin
                    head = quotients_due.pop_front();
                    n_checked++;
                    if (rsp.quotient !== head.want.quotient)
                        report_mismatch($sformatf("%0d / %0d quotient %0d, expected %0d",
                                                  head.op.dividend, head.op.divisor,
                                                  rsp.quotient, head.want.quotient));
                    if (rsp.overflow !== head.want.overflow)
                        report_mismatch($sformatf("%0d / %0d overflow %b, expected %b",
                                                  head.op.dividend, head.op.divisor,
                                                  rsp.overflow, head.want.overflow));
                    if (rsp.divide_by_zero !== head.want.divide_by_zero)
                        report_mismatch($sformatf("%0d / %0d divide_by_zero %b, expected %b",
                                                  head.op.dividend, head.op.divisor,
                                                  rsp.divide_by_zero,
                                                  head.want.divide_by_zero));
                    if (head.want.overflow)
                        n_overflow++;
                    if (head.want.divide_by_zero)
                        n_zero_div++;
                    if (head.want.quotient < 0)
                        n_negative++;
                end
            end
            if (start && !busy)
            begin
                head.op   = req;
                head.want = divide_truncated(req);
                quotients_due.push_back(head);
                n_taken++;
            end
            n_due = quotients_due.size();
        end
    end

endmodule

[test/signed_int_divider_tb.sv]
// ----------------------------------------------------------------------------
// signed_int_divider_tb
// Drives the signed divider with a directed set of corner operands (extreme
// values, every sign combination, zero divisor, the saturating case) and
// then with random requests of mixed magnitude, with random gaps between
// some requests. Checking is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module signed_int_divider_tb;
    import sid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1500;
    localparam logic signed [SID_WIDTH-1:0] MOST_NEG = {1'b1, {(SID_WIDTH-1){1'b0}}};
    localparam logic signed [SID_WIDTH-1:0] MOST_POS = {1'b0, {(SID_WIDTH-1){1'b1}}};

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    sid_req_t    req   = '0;
    logic        busy;
    logic        done;
    sid_rsp_t    rsp;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned requests_taken;
    int unsigned results_checked;
    int unsigned overflows_seen;
    int unsigned zero_divides_seen;
    int unsigned negatives_seen;

    bit gaps_on = 1'b1;

    always #5 clk = ~clk;

    signed_int_divider dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    signed_int_divider_checker check (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .req               (req),
        .done              (done),
        .rsp               (rsp),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .requests_taken    (requests_taken),
        .results_checked   (results_checked),
        .overflows_seen    (overflows_seen),
        .zero_divides_seen (zero_divides_seen),
        .negatives_seen    (negatives_seen)
    );

    function automatic logic signed [SID_WIDTH-1:0] random_operand();
        logic signed [SID_WIDTH-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: v = v >> $urandom_range(0, SID_WIDTH - 1);
            1: v = $signed(v) >>> $urandom_range(0, SID_WIDTH - 1);
            default: ;
        endcase
        return v;
    endfunction

    // request, then hold start until it is taken; start then stays high unless a gap follows
    task automatic issue(input logic signed [SID_WIDTH-1:0] a,
                         input logic signed [SID_WIDTH-1:0] b);
        start        <= 1'b1;
        req.dividend <= a;
        req.divisor  <= b;
        do
            @(posedge clk);
        while (busy);
        if (gaps_on && $urandom_range(0, 99) < 12)
        begin
            start <= 1'b0;
            req   <= {$urandom, $urandom};
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("signed_int_divider verification failed");
        $finish;
    end

    initial
    begin
        logic signed [SID_WIDTH-1:0] a;
        logic signed [SID_WIDTH-1:0] b;
        int unsigned                 guard;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(32'sd5, 32'sd0);
        issue(MOST_NEG, 32'sd0);
        issue(32'sd0, 32'sd0);
        issue(MOST_NEG, -32'sd1);
        issue(MOST_NEG, 32'sd1);
        issue(MOST_NEG, MOST_NEG);
        issue(MOST_POS, MOST_NEG);
        issue(MOST_NEG, MOST_POS);
        issue(MOST_POS, -32'sd1);
        issue(MOST_POS, 32'sd1);
        issue(MOST_POS, MOST_POS);
        issue(32'sd0, -32'sd7);
        issue(32'sd0, MOST_NEG);
        issue(-32'sd7, 32'sd2);
        issue(32'sd7, -32'sd2);
        issue(-32'sd7, -32'sd2);
        issue(32'sd1, MOST_NEG);
        issue(-32'sd1, 32'sd1);
        issue(32'sd100, 32'sd7);
        issue(MOST_NEG, 32'sd2);
        issue(MOST_NEG, -32'sd2);
        issue(-32'sd1, 32'sd0);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            gaps_on = (n < 500 || n >= 900);
            case ($urandom_range(0, 99)) inside
                [0:39]:
                begin
                    a = $urandom;
                    b = $urandom;
                end
                [40:59]:
                begin
                    a = $urandom;
                    b = $signed($urandom_range(0, 32)) - 16;
                end
                [60:67]:
                begin
                    a = random_operand();
                    b = '0;
                end
                [68:72]:
                begin
                    a = MOST_NEG;
                    b = -32'sd1;
                end
                [73:84]:
                begin
                    case ($urandom_range(0, 4))
                        0: a = MOST_NEG;
                        1: a = MOST_POS;
                        2: a = '0;
                        3: a = -32'sd1;
                        default: a = 32'sd1;
                    endcase
                    b = $urandom_range(0, 1) ? random_operand() : (a ^ $urandom_range(0, 1));
                end
                default:
                begin
                    a = random_operand();
                    b = random_operand();
                end
            endcase
            issue(a, b);
        end
        start <= 1'b0;

        guard = 0;
        while (outstanding != 0 && guard < 200)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (40) @(negedge clk);

        $display("covered %0d requests, %0d results compared", requests_taken,
                 results_checked);
        $display("of these %0d saturated, %0d by zero, %0d negative; %0d never arrived",
                 overflows_seen, zero_divides_seen, negatives_seen, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("signed_int_divider verification clean");
        else
            $display("signed_int_divider verification failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sid_pkg.sv
hw/rtl/sid_cell.sv
hw/rtl/signed_int_divider.sv
test/signed_int_divider_checker.sv
test/signed_int_divider_tb.sv
